[rtl/b64d_pkg.sv]
package b64d_pkg;

  // Result status codes
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_END      = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Halt modes of the decoder; the error modes share the error status codes
  localparam logic [1:0] HALT_RUN      = 2'd0;
  localparam logic [1:0] HALT_PAD      = 2'd1;
  localparam logic [1:0] HALT_INVALID  = 2'd2;
  localparam logic [1:0] HALT_OVERFLOW = 2'd3;

  // Character codes with a meaning of their own
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int ACC_W   = 13;
  localparam int PEND_W  = 4;
  localparam int COUNT_OUT_W = 16;

  // One result word as it leaves the block
  typedef struct packed {
    logic [7:0]             byte_value;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] byte_count;
    logic                   final_result;
  } res_t;

  // Results produced by one decoded character
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Sextet lookup: bit 6 set for a valid base64url character
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] res;
    res = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      res = {1'b1, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      res = {1'b1, 6'(ch - 8'h61 + 8'd26)};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, 6'(ch - 8'h30 + 8'd52)};
    end else if (ch == CH_DASH) begin
      res = {1'b1, 6'd62};
    end else if (ch == CH_UNDER) begin
      res = {1'b1, 6'd63};
    end
    return res;
  endfunction

endpackage

[rtl/b64d_core.sv]
module b64d_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          char_code,
  input  logic                end_of_string,
  input  logic [15:0]         capacity,
  input  logic                room,
  output logic                push,
  output b64d_pkg::push_t     push_data
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // Input register
  logic       ireg_valid;
  logic [7:0] ireg_char;
  logic       ireg_eos;
  logic       fire;

  // Per-string decoding state
  logic [b64d_pkg::ACC_W-1:0]  acc, acc_next;
  logic [b64d_pkg::PEND_W-1:0] pend, pend_next;
  logic [COUNT_WIDTH-1:0]      cnt, cnt_next;
  logic [1:0]                  halt, halt_next;

  // Decode temporaries
  logic [6:0]                  sext;
  logic [b64d_pkg::ACC_W-1:0]  acc_new;
  logic [b64d_pkg::PEND_W-1:0] pend_new;
  logic [b64d_pkg::PEND_W-1:0] shamt;
  logic                        is_skip;
  logic                        over;
  logic                        err_now;
  logic [1:0]                  end_status;
  b64d_pkg::res_t              end_res;

  assign fire     = ireg_valid & room;
  assign in_stall = ireg_valid & ~room;

  // The input register takes a new word whenever its current word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (!in_stall) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ireg_char <= char_code;
      ireg_eos  <= end_of_string;
    end
  end

  // Decode of one character against the current state
  always_comb begin
    acc_next   = acc;
    pend_next  = pend;
    cnt_next   = cnt;
    halt_next  = halt;
    push_data  = '0;
    err_now    = 1'b0;
    end_status = b64d_pkg::ST_END;
    end_res    = '0;
    sext       = b64d_pkg::sextet_of(ireg_char);
    acc_new    = {acc[b64d_pkg::ACC_W-7:0], sext[5:0]};
    pend_new   = pend + 4'd6;
    shamt      = pend_new - 4'd8;
    is_skip    = (ireg_char == b64d_pkg::CH_LF) || (ireg_char == b64d_pkg::CH_CR) ||
                 (ireg_char == b64d_pkg::CH_SPACE);
    over       = (CMP_W'(cnt) >= CMP_W'(capacity)) || (cnt == {COUNT_WIDTH{1'b1}});

    if (halt == b64d_pkg::HALT_RUN && !is_skip) begin
      if (ireg_char == b64d_pkg::CH_PAD) begin
        halt_next = b64d_pkg::HALT_PAD;
      end else if (!sext[6]) begin
        halt_next         = b64d_pkg::HALT_INVALID;
        push_data.r0      = '{8'd0, b64d_pkg::ST_INVALID, 16'(cnt), ireg_eos};
        push_data.num     = 2'd1;
        err_now           = 1'b1;
      end else begin
        acc_next  = acc_new;
        pend_next = pend_new;
        if (pend_new >= 4'd8) begin
          if (over) begin
            halt_next     = b64d_pkg::HALT_OVERFLOW;
            push_data.r0  = '{8'd0, b64d_pkg::ST_OVERFLOW, 16'(cnt), ireg_eos};
            push_data.num = 2'd1;
            err_now       = 1'b1;
          end else begin
            pend_next     = shamt;
            cnt_next      = cnt + 1'b1;
            push_data.r0  = '{8'(acc_new >> shamt), b64d_pkg::ST_DATA,
                              16'(cnt + 1'b1), 1'b0};
            push_data.num = 2'd1;
          end
        end
      end
    end

    // End of string: give the closing result unless an error just closed it
    if (ireg_eos) begin
      if (halt_next == b64d_pkg::HALT_INVALID || halt_next == b64d_pkg::HALT_OVERFLOW) begin
        end_status = halt_next;
      end
      end_res = '{8'd0, end_status, 16'(cnt_next), 1'b1};
      if (!err_now) begin
        if (push_data.num == 2'd0) begin
          push_data.r0 = end_res;
        end else begin
          push_data.r1 = end_res;
        end
        push_data.num = push_data.num + 2'd1;
      end
      acc_next  = '0;
      pend_next = '0;
      cnt_next  = '0;
      halt_next = b64d_pkg::HALT_RUN;
    end
  end

  assign push = fire;

  // State advances only when the decoded word is handed to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pend <= '0;
      cnt  <= '0;
      halt <= b64d_pkg::HALT_RUN;
    end else if (fire) begin
      acc  <= acc_next;
      pend <= pend_next;
      cnt  <= cnt_next;
      halt <= halt_next;
    end
  end

endmodule

[rtl/b64d_outq.sv]
module b64d_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64d_pkg::push_t   push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output b64d_pkg::res_t    out_res
);

  // Four-entry result queue, up to two writes and one read per cycle
  b64d_pkg::res_t mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count, count_next;
  logic [1:0] num_in;
  logic       pop;

  assign num_in    = push ? push_data.num : 2'd0;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid & ~out_stall;
  assign room      = (count <= 3'd2);
  assign out_res   = mem[rptr];

  assign count_next = count + 3'(num_in) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + num_in;
      rptr  <= rptr + 2'(pop);
      count <= count_next;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (num_in != 2'd0) begin
      mem[wptr] <= push_data.r0;
    end
    if (num_in == 2'd2) begin
      mem[wptr + 2'd1] <= push_data.r1;
    end
  end

endmodule

[rtl/base64url_stream_decoder_top.sv]
// Base64url stream decoder.
// Input channel (in_valid / in_stall): one character word per cycle unless
// stalled, with end_of_string set on the last character of a string.
// Output channel (out_valid / out_stall): result words of byte_value,
// status, byte_count and final_result; every string closes with exactly
// one word that has final_result set.
// Configuration channel (cfg_valid / cfg_ready): writes out_capacity, the
// byte limit per string; cfg_ready is always high. Write it only while idle.
// From input acceptance, the input register feeds the decode, which writes
// the four-entry result queue, and the first result word is offered from
// the queue. Throughput is one character per cycle unless in_stall holds it; a
// character that yields two results (a data byte on the last character)
// takes two output words, and the queue absorbs that.
// A stalled receiver fills the queue; once fewer than two entries are free
// the decoder holds its word and in_stall rises.
// Synchronous reset empties the queue, clears the per-string state and sets
// out_capacity to 65535.
module base64url_stream_decoder_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_value,
  output logic [1:0]  status,
  output logic [15:0] byte_count,
  output logic        final_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] out_capacity
);

  logic [15:0]     capacity;
  logic            room;
  logic            push;
  b64d_pkg::push_t push_data;
  b64d_pkg::res_t  out_res;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= out_capacity;
    end
  end

  b64d_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .capacity      (capacity),
    .room          (room),
    .push          (push),
    .push_data     (push_data)
  );

  b64d_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign byte_value   = out_res.byte_value;
  assign status       = out_res.status;
  assign byte_count   = out_res.byte_count;
  assign final_result = out_res.final_result;

endmodule
